### hw/rtl/cpsct_pkg.sv
// Shared constants and types for the convex plane set cull test unit.
package cpsct_pkg;

    // Defaults for the top level parameters.
    localparam int MAX_PLANES_DEF  = 6;
    localparam int COORD_WIDTH_DEF = 16;

    // Plane register packing: three Q2.14 normal components, then d in Q12.4.
    localparam int NORM_W  = 16;
    localparam int D_W     = 16;
    localparam int PLANE_W = 3 * NORM_W + D_W;
    localparam int D_LSB   = 3 * NORM_W;

    // Scaling of d into the dot product formats.
    localparam int BOX_SHIFT = 15;
    localparam int SPH_SHIFT = 14;

    // Configuration port geometry: 64-bit registers at byte address 8*i.
    localparam int PDATA_W   = 64;
    localparam int PADDR_W   = 6;
    localparam int REG_SHIFT = 3;
    localparam int IDX_W     = PADDR_W - REG_SHIFT;
    localparam int CNT_W     = 3;

    // Register indexes.
    localparam logic [IDX_W-1:0] REG_PLANE_COUNT = 3'd0;
    localparam int               PLANE_REG_LIMIT = 6;

    // Operation codes.
    localparam logic OP_BOX    = 1'b0;
    localparam logic OP_SPHERE = 1'b1;

    // Per-stage advance enables handed to the plane lanes.
    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
    } cpsct_stage_en_t;

endpackage

### hw/rtl/cpsct_plane_lane.sv
// One plane's share of the cull pipeline: operand select, multiply, sum and compare.
module cpsct_plane_lane
    import cpsct_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic                          clk,
    input  cpsct_stage_en_t               en,
    input  logic [PLANE_W-1:0]            plane,
    input  logic                          op,
    input  logic signed [COORD_WIDTH-1:0] pos [3],
    input  logic [COORD_WIDTH-2:0]        size [3],
    input  logic [COORD_WIDTH-2:0]        radius,
    output logic                          cull
);

    localparam int OPW = COORD_WIDTH + 2;
    localparam int PW  = OPW + NORM_W;
    localparam int SW  = PW + 2;
    localparam int DRW = ((COORD_WIDTH > D_W) ? COORD_WIDTH : D_W) + 1;
    localparam int TW  = ((DRW + SPH_SHIFT) > (D_W + BOX_SHIFT)) ?
                         (DRW + SPH_SHIFT) : (D_W + BOX_SHIFT);
    localparam int CW  = ((SW > TW) ? SW : TW) + 1;

    logic signed [NORM_W-1:0] norm [3];
    logic signed [D_W-1:0]    plane_d;

    logic signed [OPW-1:0] pos_ext  [3];
    logic signed [OPW-1:0] size_ext [3];
    logic signed [OPW-1:0] term     [3];
    logic signed [OPW-1:0] opnd_next [3];
    logic signed [OPW-1:0] opnd_reg  [3];

    logic signed [DRW-1:0] rad_sum;
    logic signed [TW-1:0]  thr_next;
    logic signed [TW-1:0]  thr2_reg;
    logic signed [TW-1:0]  thr3_reg;
    logic                  op2_reg;
    logic                  op3_reg;

    logic signed [PW-1:0]  prod_reg [3];
    logic signed [SW-1:0]  dot_sum;
    logic signed [CW-1:0]  dot_cmp;
    logic signed [CW-1:0]  thr_cmp;
    logic                  cull_next;
    logic                  cull_reg;

    assign plane_d = D_W'(signed'(plane[D_LSB +: D_W]));

    // Box mode picks the vertex most opposite to the normal, at doubled scale:
    // 2*pos plus size times (1 - sign(n)).
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            norm[a]     = signed'(plane[a*NORM_W +: NORM_W]);
            pos_ext[a]  = OPW'(pos[a]);
            size_ext[a] = OPW'({1'b0, size[a]});
            if (norm[a][NORM_W-1])
                term[a] = size_ext[a] <<< 1;
            else if (norm[a] == '0)
                term[a] = size_ext[a];
            else
                term[a] = '0;
            if (op == OP_SPHERE)
                opnd_next[a] = pos_ext[a];
            else
                opnd_next[a] = (pos_ext[a] <<< 1) + term[a];
        end
        rad_sum = DRW'(plane_d) + DRW'(signed'({1'b0, radius}));
        if (op == OP_SPHERE)
            thr_next = TW'(rad_sum) <<< SPH_SHIFT;
        else
            thr_next = TW'(plane_d) <<< BOX_SHIFT;
    end

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            opnd_reg <= opnd_next;
            thr2_reg <= thr_next;
            op2_reg  <= op;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            for (int a = 0; a < 3; a++)
                prod_reg[a] <= PW'(opnd_reg[a]) * PW'(norm[a]);
            thr3_reg <= thr2_reg;
            op3_reg  <= op2_reg;
        end
    end

    // A sphere is culled at equality, a box only strictly beyond d.
    always_comb
    begin
        dot_sum = SW'(prod_reg[0]) + SW'(prod_reg[1]) + SW'(prod_reg[2]);
        dot_cmp = CW'(dot_sum);
        thr_cmp = CW'(thr3_reg);
        if (op3_reg == OP_SPHERE)
            cull_next = (dot_cmp >= thr_cmp);
        else
            cull_next = (dot_cmp > thr_cmp);
    end

    always_ff @(posedge clk)
    begin
        if (en.s4)
            cull_reg <= cull_next;
    end

    assign cull = cull_reg;

endmodule

### hw/rtl/convex_plane_set_cull_test_unit.sv
// Top level of the convex plane set cull test unit: config registers and pipeline control.
//
//  Channel   Signals                                        Direction
//  input     in_valid, in_ready, operation, pos_*, size_*,  request in
//            radius
//  output    out_valid, out_ready, inside_res               result out
//  config    psel, penable, pwrite, paddr, pwdata, prdata,  APB-style register port
//            pready
//
// Each request passes through the stages in order: input register, operand select,
// multiply, sum and compare, and the output register. A new request is taken every
// cycle while the pipe is not backed up, as each stage hands on its request. Reset
// clears the valid bits, the plane count and the plane registers. A stall at the
// output backs up only through occupied stages, so empty stages still fill.
module convex_plane_set_cull_test_unit
    import cpsct_pkg::*;
#(
    parameter int MAX_PLANES  = MAX_PLANES_DEF,
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          operation,
    input  logic signed [COORD_WIDTH-1:0] pos_x,
    input  logic signed [COORD_WIDTH-1:0] pos_y,
    input  logic signed [COORD_WIDTH-1:0] pos_z,
    input  logic [COORD_WIDTH-2:0]        size_x,
    input  logic [COORD_WIDTH-2:0]        size_y,
    input  logic [COORD_WIDTH-2:0]        size_z,
    input  logic [COORD_WIDTH-2:0]        radius,

    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          inside_res,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [PADDR_W-1:0]            paddr,
    input  logic [PDATA_W-1:0]            pwdata,
    output logic [PDATA_W-1:0]            prdata,
    output logic                          pready
);

    logic [CNT_W-1:0]   count_reg;
    logic [PLANE_W-1:0] plane_reg [MAX_PLANES];
    logic [IDX_W-1:0]   reg_idx;
    logic               cfg_wr;
    logic [CNT_W-1:0]   count_eff;
    logic [MAX_PLANES-1:0] active;
    logic [MAX_PLANES-1:0] cull;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic en1, en2, en3, en4, en5;
    cpsct_stage_en_t lane_en;

    logic                          op1_reg;
    logic signed [COORD_WIDTH-1:0] pos1_reg  [3];
    logic [COORD_WIDTH-2:0]        size1_reg [3];
    logic [COORD_WIDTH-2:0]        rad1_reg;
    logic                          inside_reg;
    logic                          inside_next;

    // Configuration registers.
    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:REG_SHIFT];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (cfg_wr && reg_idx == REG_PLANE_COUNT)
            count_reg <= pwdata[CNT_W-1:0];
    end

    for (genvar i = 0; i < MAX_PLANES; i++)
    begin : g_plane_reg
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                plane_reg[i] <= '0;
            else if (cfg_wr && reg_idx == IDX_W'(i + 1) && (i + 1) <= PLANE_REG_LIMIT)
                plane_reg[i] <= pwdata[PLANE_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_idx == REG_PLANE_COUNT)
            prdata = PDATA_W'(count_reg);
        for (int i = 0; i < MAX_PLANES; i++)
        begin
            if (reg_idx == IDX_W'(i + 1))
                prdata = PDATA_W'(plane_reg[i]);
        end
    end

    // Plane counts above the number of lanes saturate.
    always_comb
    begin
        if (count_reg > CNT_W'(MAX_PLANES))
            count_eff = CNT_W'(MAX_PLANES);
        else
            count_eff = count_reg;
        for (int i = 0; i < MAX_PLANES; i++)
            active[i] = (CNT_W'(i) < count_eff);
    end

    // Each stage moves when it is empty or the stage after it moves.
    assign en5      = !v5_reg || out_ready;
    assign en4      = !v4_reg || en5;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;
    assign lane_en  = '{s2: en2, s3: en3, s4: en4};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                v1_reg <= in_valid;
            if (en2)
                v2_reg <= v1_reg;
            if (en3)
                v3_reg <= v2_reg;
            if (en4)
                v4_reg <= v3_reg;
            if (en5)
                v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            op1_reg      <= operation;
            pos1_reg[0]  <= pos_x;
            pos1_reg[1]  <= pos_y;
            pos1_reg[2]  <= pos_z;
            size1_reg[0] <= size_x;
            size1_reg[1] <= size_y;
            size1_reg[2] <= size_z;
            rad1_reg     <= radius;
        end
    end

    for (genvar i = 0; i < MAX_PLANES; i++)
    begin : g_lane
        cpsct_plane_lane #(
            .COORD_WIDTH (COORD_WIDTH)
        ) u_lane (
            .clk    (clk),
            .en     (lane_en),
            .plane  (plane_reg[i]),
            .op     (op1_reg),
            .pos    (pos1_reg),
            .size   (size1_reg),
            .radius (rad1_reg),
            .cull   (cull[i])
        );
    end

    assign inside_next = !(|(cull & active));

    always_ff @(posedge clk)
    begin
        if (en5)
            inside_reg <= inside_next;
    end

    assign out_valid  = v5_reg;
    assign inside_res = inside_reg;

endmodule

### hw/rtl/cpsct_checker.sv
// Port-level checker for the convex plane set cull test unit, with its bind.
module cpsct_checker
    import cpsct_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic               inside_res,
    input logic               psel,
    input logic               penable,
    input logic               pwrite,
    input logic [PADDR_W-1:0] paddr,
    input logic [PDATA_W-1:0] pwdata,
    input logic [PDATA_W-1:0] prdata,
    input logic               pready
);

    // A held result keeps its value until taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(inside_res))
        else $error("result changed while stalled");

    // With the output register empty, the whole pipe can advance.
    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    // The plane count reads back what was just written.
    a_count_readback: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && paddr[PADDR_W-1:REG_SHIFT] == REG_PLANE_COUNT)
        ##1 (psel && !pwrite && paddr[PADDR_W-1:REG_SHIFT] == REG_PLANE_COUNT)
        |-> prdata == PDATA_W'($past(pwdata[CNT_W-1:0])))
        else $error("plane count readback mismatch");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready low");

endmodule

bind convex_plane_set_cull_test_unit cpsct_checker u_cpsct_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .inside_res (inside_res),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
);

### tb/convex_plane_set_cull_test_unit_tb.sv
// Self-checking testbench for the convex plane set cull test unit.
`timescale 1ns / 100ps

module convex_plane_set_cull_test_unit_tb
    import cpsct_pkg::*;
();

    localparam int CW             = COORD_WIDTH_DEF;
    localparam int NPLANES        = MAX_PLANES_DEF;
    localparam int REG_PLANE_BASE = 1;
    localparam int REG_UNUSED     = 7;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 8;
    localparam int CYCLE_LIMIT    = 200000;
    localparam logic [NORM_W-1:0] NORM_ONE = 16'h4000;

    typedef struct packed {
        logic          op;
        logic [CW-1:0] px;
        logic [CW-1:0] py;
        logic [CW-1:0] pz;
        logic [CW-2:0] sx;
        logic [CW-2:0] sy;
        logic [CW-2:0] sz;
        logic [CW-2:0] rad;
    } cull_req_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic                 operation;
    logic signed [CW-1:0] pos_x;
    logic signed [CW-1:0] pos_y;
    logic signed [CW-1:0] pos_z;
    logic [CW-2:0]        size_x;
    logic [CW-2:0]        size_y;
    logic [CW-2:0]        size_z;
    logic [CW-2:0]        radius;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic                 inside_res;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [PADDR_W-1:0]   paddr = '0;
    logic [PDATA_W-1:0]   pwdata = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    cull_req_t    cur_req = '0;
    cull_req_t    req_pending_q[$];
    logic         inside_expected_q[$];
    logic         want_inside;
    logic [CNT_W-1:0]   plane_count_cfg = '0;
    logic [PLANE_W-1:0] plane_cfg[NPLANES];
    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;
    int           recv_hold_left = 0;
    bit           hold_start = 1'b0;
    int           err_count = 0;
    int           cycle_count = 0;

    assign operation = cur_req.op;
    assign pos_x     = cur_req.px;
    assign pos_y     = cur_req.py;
    assign pos_z     = cur_req.pz;
    assign size_x    = cur_req.sx;
    assign size_y    = cur_req.sy;
    assign size_z    = cur_req.sz;
    assign radius    = cur_req.rad;

    convex_plane_set_cull_test_unit uut (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Box test uses doubled coordinates so that half sizes stay exact; the vertex
    // sits at the corner opposite the normal, or mid-box where a component is zero.
    function automatic logic predict_inside(input cull_req_t r);
        longint p[3];
        longint s[3];
        longint n[3];
        longint d;
        longint dot;
        longint sg;
        longint rad;
        int     active;
        logic   pass;
        p[0] = longint'($signed(r.px));
        p[1] = longint'($signed(r.py));
        p[2] = longint'($signed(r.pz));
        s[0] = longint'(r.sx);
        s[1] = longint'(r.sy);
        s[2] = longint'(r.sz);
        rad = longint'(r.rad);
        active = (plane_count_cfg > NPLANES) ? NPLANES : int'(plane_count_cfg);
        pass = 1'b1;
        for (int i = 0; i < active; i++)
        begin
            for (int a = 0; a < 3; a++)
                n[a] = longint'($signed(plane_cfg[i][NORM_W*a +: NORM_W]));
            d = longint'($signed(plane_cfg[i][D_LSB +: D_W]));
            dot = 0;
            if (r.op == OP_SPHERE)
            begin
                for (int a = 0; a < 3; a++)
                    dot += p[a] * n[a];
                if (dot - (d <<< SPH_SHIFT) >= (rad <<< SPH_SHIFT))
                    pass = 1'b0;
            end
            else
            begin
                for (int a = 0; a < 3; a++)
                begin
                    sg = (n[a] > 0) ? 1 : ((n[a] < 0) ? -1 : 0);
                    dot += (2 * p[a] + s[a] * (1 - sg)) * n[a];
                end
                if (dot > (d <<< BOX_SHIFT))
                    pass = 1'b0;
            end
        end
        return pass;
    endfunction

    function automatic logic [PLANE_W-1:0] plane_word(input logic [NORM_W-1:0] nx,
                                                      input logic [NORM_W-1:0] ny,
                                                      input logic [NORM_W-1:0] nz,
                                                      input logic [D_W-1:0] d);
        return {d, nz, ny, nx};
    endfunction

    function automatic logic [NORM_W-1:0] rand_norm(input int kind);
        logic [NORM_W-1:0] v;
        case (kind)
            0:       v = NORM_ONE;
            1:       v = -NORM_ONE;
            2:       v = '0;
            3:       v = NORM_W'($urandom_range(0, 2047)) - NORM_W'(1024);
            default: v = NORM_W'($urandom);
        endcase
        return v;
    endfunction

    function automatic logic [PLANE_W-1:0] rand_plane();
        logic [NORM_W-1:0] n[3];
        logic [D_W-1:0]    d;
        int                axis;
        axis = $urandom_range(2);
        for (int a = 0; a < 3; a++)
        begin
            if ($urandom_range(2) == 0)
                n[a] = (a == axis) ? rand_norm($urandom_range(1)) : '0;
            else
                n[a] = rand_norm($urandom_range(2, 4));
        end
        d = ($urandom_range(2) != 0) ? D_W'($urandom_range(0, 1023)) - D_W'(512)
                                     : D_W'($urandom);
        return plane_word(n[0], n[1], n[2], d);
    endfunction

    // Coordinates cluster around the origin so that plane tests land on both sides.
    function automatic logic [CW-1:0] rand_coord();
        logic [CW-1:0] v;
        case ($urandom_range(7))
            0, 1:    v = CW'($urandom);
            6:       v = {1'b1, {(CW-1){1'b0}}};
            7:       v = {1'b0, {(CW-1){1'b1}}};
            default: v = CW'($urandom_range(0, 1023)) - CW'(512);
        endcase
        return v;
    endfunction

    function automatic logic [CW-2:0] rand_size();
        logic [CW-2:0] v;
        case ($urandom_range(7))
            0, 1:    v = (CW-1)'($urandom);
            6:       v = '0;
            7:       v = '1;
            default: v = (CW-1)'($urandom_range(0, 1023));
        endcase
        return v;
    endfunction

    task automatic add_req(input logic op, input int px, input int py, input int pz,
                           input int sx, input int sy, input int sz, input int rad);
        cull_req_t r;
        r.op  = op;
        r.px  = CW'(px);
        r.py  = CW'(py);
        r.pz  = CW'(pz);
        r.sx  = (CW-1)'(sx);
        r.sy  = (CW-1)'(sy);
        r.sz  = (CW-1)'(sz);
        r.rad = (CW-1)'(rad);
        req_pending_q.push_back(r);
    endtask

    task automatic add_random_reqs(input int count);
        cull_req_t r;
        for (int i = 0; i < count; i++)
        begin
            r.op  = $urandom_range(1) ? OP_SPHERE : OP_BOX;
            r.px  = rand_coord();
            r.py  = rand_coord();
            r.pz  = rand_coord();
            r.sx  = rand_size();
            r.sy  = rand_size();
            r.sz  = rand_size();
            r.rad = rand_size();
            req_pending_q.push_back(r);
        end
    endtask

    task automatic write_reg(input int idx, input logic [PDATA_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(idx << REG_SHIFT);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == int'(REG_PLANE_COUNT))
            plane_count_cfg = value[CNT_W-1:0];
        else if (idx >= REG_PLANE_BASE && idx < REG_PLANE_BASE + PLANE_REG_LIMIT)
            plane_cfg[idx - REG_PLANE_BASE] = value;
    endtask

    // Waits until every request is accepted and every result has come back.
    task automatic drain();
        while (req_pending_q.size() != 0 || in_valid || inside_expected_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic report_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        err_count++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                inside_expected_q.push_back(predict_inside(cur_req));
            if (!in_valid || in_ready)
            begin
                if (req_pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    cur_req  <= req_pending_q.pop_front();
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (inside_expected_q.size() == 0)
                begin
                    report_mismatch($sformatf("inside_res=%0b with no request outstanding",
                                              inside_res));
                end
                else
                begin
                    want_inside = inside_expected_q.pop_front();
                    if (inside_res !== want_inside)
                        report_mismatch($sformatf("inside_res=%0b, expected %0b",
                                                  inside_res, want_inside));
                end
            end
            out_ready <= (recv_hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (hold_start)
            recv_hold_left <= HOLD_CYCLES;
        else if (recv_hold_left != 0)
            recv_hold_left <= recv_hold_left - 1;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("convex_plane_set_cull_test_unit_tb NOT OK");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < NPLANES; i++)
            plane_cfg[i] = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // With no planes active everything passes.
        write_reg(int'(REG_PLANE_COUNT), 0);
        add_req(OP_BOX, -32768, -32768, -32768, 0, 0, 0, 32767);
        add_req(OP_BOX, 32767, 32767, 32767, 32767, 32767, 32767, 0);
        add_req(OP_SPHERE, -32768, -32768, -32768, 32767, 32767, 32767, 0);
        add_req(OP_SPHERE, 32767, 32767, 32767, 0, 0, 0, 32767);
        drain();

        // Plane 0 keeps x <= 0, plane 1 keeps y >= 0; the rest never cull.
        // A count above the plane limit saturates, and a spare index is ignored.
        write_reg(REG_PLANE_BASE + 0, plane_word(NORM_ONE, '0, '0, '0));
        write_reg(REG_PLANE_BASE + 1, plane_word('0, -NORM_ONE, '0, '0));
        for (int i = 2; i < NPLANES; i++)
            write_reg(REG_PLANE_BASE + i, plane_word('0, '0, '0, 16'h7fff));
        write_reg(int'(REG_PLANE_COUNT), 7);
        write_reg(REG_UNUSED, '1);
        add_req(OP_BOX, 0, 0, 0, 0, 0, 0, 0);
        add_req(OP_BOX, 1, 0, 0, 0, 0, 0, 0);
        add_req(OP_BOX, -32768, -16, 0, 0, 16, 0, 32767);
        add_req(OP_BOX, 0, -16, 0, 0, 15, 0, 0);
        add_req(OP_BOX, -32768, 32767, -32768, 32767, 32767, 32767, 0);
        add_req(OP_BOX, 32767, 0, 32767, 0, 0, 0, 0);
        add_req(OP_SPHERE, 32, 0, 0, 32767, 0, 0, 32);
        add_req(OP_SPHERE, 32, 0, 0, 0, 0, 0, 33);
        add_req(OP_SPHERE, 32767, 0, 0, 0, 0, 0, 32767);
        add_req(OP_SPHERE, -32768, 32767, 0, 0, 0, 0, 0);
        add_req(OP_SPHERE, 0, 0, 0, 0, 0, 0, 0);
        add_req(OP_SPHERE, -32768, -32768, -32768, 0, 0, 0, 32767);
        drain();

        for (int ph = 0; ph < 5; ph++)
        begin
            for (int i = 0; i < NPLANES; i++)
                write_reg(REG_PLANE_BASE + i, rand_plane());
            case (ph)
                0:
                begin
                    write_reg(int'(REG_PLANE_COUNT), PDATA_W'(NPLANES));
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
                1:
                begin
                    write_reg(int'(REG_PLANE_COUNT),
                              PDATA_W'($urandom_range(1, NPLANES - 1)));
                    send_idle_pct = 62;
                    recv_idle_pct = 0;
                end
                2:
                begin
                    // Full-scale register contents: all ones and all zeros.
                    write_reg(REG_PLANE_BASE + 0, '1);
                    write_reg(REG_PLANE_BASE + 1, '0);
                    write_reg(int'(REG_PLANE_COUNT), 2);
                    send_idle_pct = 0;
                    recv_idle_pct = 62;
                end
                3:
                begin
                    write_reg(int'(REG_PLANE_COUNT), PDATA_W'($urandom_range(0, 7)));
                    send_idle_pct = 21;
                    recv_idle_pct = 21;
                end
                default:
                begin
                    write_reg(int'(REG_PLANE_COUNT), PDATA_W'($urandom_range(3, 7)));
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            @(negedge clk);
            if (ph == 4)
            begin
                // Long receiver hold-off while requests keep coming, to back up the pipe.
                hold_start = 1'b1;
                @(negedge clk);
                hold_start = 1'b0;
                add_random_reqs(60);
                drain();
            end
            else
            begin
                // The sender pauses halfway until every result is back.
                add_random_reqs(50);
                drain();
                add_random_reqs(50);
                drain();
            end
        end

        repeat (10) @(posedge clk);
        if (err_count == 0)
            $display("convex_plane_set_cull_test_unit_tb OK");
        else
            $display("convex_plane_set_cull_test_unit_tb NOT OK");
        $finish;
    end

endmodule

### files.f
hw/rtl/cpsct_pkg.sv
hw/rtl/cpsct_plane_lane.sv
hw/rtl/convex_plane_set_cull_test_unit.sv
hw/rtl/cpsct_checker.sv
tb/convex_plane_set_cull_test_unit_tb.sv
